>>> rtl/zlx_pkg.sv
// ----------------------------------------------------------------------------
// zlx_pkg: shared types and constants
// Register codes, form codes, result codes and the decoded-instruction record.
// ----------------------------------------------------------------------------
package zlx_pkg;

	localparam int unsigned MEMORY_SIZE = 65536;

	localparam logic [4:0] R_A   = 5'd0;
	localparam logic [4:0] R_I   = 5'd7;
	localparam logic [4:0] R_R   = 5'd8;
	localparam logic [4:0] R_BC  = 5'd9;
	localparam logic [4:0] R_DE  = 5'd10;
	localparam logic [4:0] R_HL  = 5'd11;
	localparam logic [4:0] R_SP  = 5'd12;
	localparam logic [4:0] R_AF  = 5'd13;
	localparam logic [4:0] R_AF2 = 5'd14;
	localparam logic [4:0] R_IX  = 5'd15;
	localparam logic [4:0] R_IY  = 5'd16;

	localparam logic [4:0] M_LD_RR    = 5'd0;
	localparam logic [4:0] M_LD_RN    = 5'd1;
	localparam logic [4:0] M_LD_RM    = 5'd2;
	localparam logic [4:0] M_LD_RX    = 5'd3;
	localparam logic [4:0] M_LD_MR    = 5'd4;
	localparam logic [4:0] M_LD_XR    = 5'd5;
	localparam logic [4:0] M_LD_MN    = 5'd6;
	localparam logic [4:0] M_LD_XN    = 5'd7;
	localparam logic [4:0] M_LD_ANN   = 5'd8;
	localparam logic [4:0] M_LD_NNA   = 5'd9;
	localparam logic [4:0] M_LD_DDNN  = 5'd10;
	localparam logic [4:0] M_LD_DDMNN = 5'd11;
	localparam logic [4:0] M_LD_MNNDD = 5'd12;
	localparam logic [4:0] M_LD_SP    = 5'd13;
	localparam logic [4:0] M_PUSH     = 5'd14;
	localparam logic [4:0] M_POP      = 5'd15;
	localparam logic [4:0] M_EX       = 5'd16;
	localparam logic [4:0] M_EX_SP    = 5'd17;
	localparam logic [4:0] M_EXX      = 5'd18;
	localparam logic [4:0] M_BLK_LO   = 5'd19;
	localparam logic [4:0] M_BLK_HI   = 5'd26;
	localparam logic [4:0] M_ORG      = 5'd27;

	localparam logic [1:0] E_OK   = 2'd0;
	localparam logic [1:0] E_REG  = 2'd1;
	localparam logic [1:0] E_MEM  = 2'd2;

	localparam int unsigned QDEPTH = 2;

	// One decoded instruction, as the front end hands it to the emitter.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      len;     // 1..4 bytes
		logic [15:0]     addr;    // address of the first byte
		logic [1:0]      err;
	} zlx_instr_t;

	typedef struct packed {
		logic [4:0]  mode;
		logic [4:0]  reg_left;
		logic [4:0]  reg_right;
		logic [7:0]  imm_byte;
		logic [7:0]  imm_byte2;
		logic [15:0] imm_word;
	} zlx_in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [15:0] out_address;
		logic        last_byte;
		logic [1:0]  error_code;
	} zlx_out_t;

	function automatic logic [3:0] reg8(input logic [4:0] r);
		// bit 3 marks a valid register; low bits are the field
		logic [2:0] f;
		f = 3'd0;
		case (r)
			5'd0: f = 3'd7;
			5'd1: f = 3'd0;
			5'd2: f = 3'd1;
			5'd3: f = 3'd2;
			5'd4: f = 3'd3;
			5'd5: f = 3'd4;
			5'd6: f = 3'd5;
			default: f = 3'd0;
		endcase
		return {(r < 5'd7), f};
	endfunction

	function automatic logic [7:0] idx_prefix(input logic [4:0] r);
		if (r == R_IX)
			return 8'hDD;
		if (r == R_IY)
			return 8'hFD;
		return 8'h00;
	endfunction

endpackage

>>> rtl/zlx_if.sv
// ----------------------------------------------------------------------------
// zlx_if: valid/ready channel
// Carries one transaction of type T between a source and a sink.
// ----------------------------------------------------------------------------
interface zlx_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/z80_load_exchange_encoder_top.sv
// ----------------------------------------------------------------------------
// z80_load_exchange_encoder_top: Z80 load/exchange/block instruction encoder
// Front end decodes a form; a two-entry queue feeds the byte emitter.
// ----------------------------------------------------------------------------
// Order: the front end writes each accepted instruction into the queue, and the
// emitter sends its bytes from the queue head. Throughput: one byte per cycle
// while out_ch is ready, through the single output port of the emitter.
// An instruction has 1 to 4 bytes; org forms and unused forms give no results.
// Reset: arst_n clears the program counter and empties the queue at once.
module z80_load_exchange_encoder_top (
	input logic clk,
	input logic arst_n,
	zlx_if.sink   in_ch,
	zlx_if.source out_ch
);
	import zlx_pkg::*;

	logic       push;
	logic       full;
	zlx_instr_t push_data;

	zlx_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.push(push), .push_data(push_data), .full(full)
	);

	zlx_back u_back (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.full(full), .out_ch(out_ch)
	);

endmodule

>>> rtl/zlx_front.sv
// ----------------------------------------------------------------------------
// zlx_front: decode and address assignment
// Encodes one form into bytes, checks memory bounds and owns the program counter.
// ----------------------------------------------------------------------------
module zlx_front (
	input  logic                  clk,
	input  logic                  arst_n,
	zlx_if.sink                   in_ch,
	output logic                  push,
	output zlx_pkg::zlx_instr_t   push_data,
	input  logic                  full
);
	import zlx_pkg::*;

	logic [16:0] pc_q;
	logic [3:0][7:0] b;
	logic [2:0] len;
	logic [3:0] a, c;
	logic [7:0] p;
	logic [1:0] ps;
	logic [7:0] lo, hi;
	logic [17:0] end_pc;
	logic [2:0] blk;
	logic is_instr;
	zlx_in_t d;

	assign d = in_ch.data;
	assign in_ch.ready = !full;
	assign lo = d.imm_word[7:0];
	assign hi = d.imm_word[15:8];
	assign blk = 3'(d.mode - M_BLK_LO);

	always_comb begin
		b = '0;
		len = 3'd0;
		a = reg8(d.reg_left);
		c = reg8(d.reg_right);
		p = 8'h00;
		ps = 2'd0;
		case (d.mode)
			M_LD_RR: begin
				if (d.reg_left == R_A && d.reg_right == R_I) begin
					b[0] = 8'hED; b[1] = 8'h57; len = 3'd2;
				end else if (d.reg_left == R_A && d.reg_right == R_R) begin
					b[0] = 8'hED; b[1] = 8'h5F; len = 3'd2;
				end else if (d.reg_left == R_I && d.reg_right == R_A) begin
					b[0] = 8'hED; b[1] = 8'h47; len = 3'd2;
				end else if (d.reg_left == R_R && d.reg_right == R_A) begin
					b[0] = 8'hED; b[1] = 8'h4F; len = 3'd2;
				end else if (a[3] && c[3]) begin
					b[0] = {2'b01, a[2:0], c[2:0]}; len = 3'd1;
				end
			end
			M_LD_RN: begin
				if (a[3]) begin
					b[0] = {2'b00, a[2:0], 3'b110}; b[1] = d.imm_byte; len = 3'd2;
				end
			end
			M_LD_RM: begin
				if (d.reg_right == R_HL && a[3]) begin
					b[0] = {2'b01, a[2:0], 3'b110}; len = 3'd1;
				end else if (d.reg_left == R_A && d.reg_right == R_BC) begin
					b[0] = 8'h0A; len = 3'd1;
				end else if (d.reg_left == R_A && d.reg_right == R_DE) begin
					b[0] = 8'h1A; len = 3'd1;
				end
			end
			M_LD_RX: begin
				p = idx_prefix(d.reg_right);
				if (a[3] && p != 8'h00) begin
					b[0] = p; b[1] = {2'b01, a[2:0], 3'b110}; b[2] = d.imm_byte;
					len = 3'd3;
				end
			end
			M_LD_MR: begin
				if (d.reg_left == R_HL && c[3]) begin
					b[0] = {5'b01110, c[2:0]}; len = 3'd1;
				end else if (d.reg_left == R_BC && d.reg_right == R_A) begin
					b[0] = 8'h02; len = 3'd1;
				end else if (d.reg_left == R_DE && d.reg_right == R_A) begin
					b[0] = 8'h12; len = 3'd1;
				end
			end
			M_LD_XR: begin
				p = idx_prefix(d.reg_left);
				if (p != 8'h00 && c[3]) begin
					b[0] = p; b[1] = {5'b01110, c[2:0]}; b[2] = d.imm_byte; len = 3'd3;
				end
			end
			M_LD_MN: begin
				if (d.reg_left == R_HL) begin
					b[0] = 8'h36; b[1] = d.imm_byte; len = 3'd2;
				end
			end
			M_LD_XN: begin
				p = idx_prefix(d.reg_left);
				if (p != 8'h00) begin
					b[0] = p; b[1] = 8'h36; b[2] = d.imm_byte; b[3] = d.imm_byte2;
					len = 3'd4;
				end
			end
			M_LD_ANN: begin
				if (d.reg_left == R_A) begin
					b[0] = 8'h3A; b[1] = lo; b[2] = hi; len = 3'd3;
				end
			end
			M_LD_NNA: begin
				if (d.reg_right == R_A) begin
					b[0] = 8'h32; b[1] = lo; b[2] = hi; len = 3'd3;
				end
			end
			M_LD_DDNN: begin
				p = idx_prefix(d.reg_left);
				ps = 2'(d.reg_left - R_BC);
				if (p != 8'h00) begin
					b[0] = p; b[1] = 8'h21; b[2] = lo; b[3] = hi; len = 3'd4;
				end else if (d.reg_left >= R_BC && d.reg_left <= R_SP) begin
					b[0] = {2'b00, ps, 4'h1}; b[1] = lo; b[2] = hi; len = 3'd3;
				end
			end
			M_LD_DDMNN: begin
				p = idx_prefix(d.reg_left);
				ps = 2'(d.reg_left - R_BC);
				if (d.reg_left == R_HL) begin
					b[0] = 8'h2A; b[1] = lo; b[2] = hi; len = 3'd3;
				end else if (p != 8'h00) begin
					b[0] = p; b[1] = 8'h2A; b[2] = lo; b[3] = hi; len = 3'd4;
				end else if (d.reg_left >= R_BC && d.reg_left <= R_SP) begin
					b[0] = 8'hED; b[1] = {2'b01, ps, 4'hB}; b[2] = lo; b[3] = hi;
					len = 3'd4;
				end
			end
			M_LD_MNNDD: begin
				p = idx_prefix(d.reg_right);
				ps = 2'(d.reg_right - R_BC);
				if (d.reg_right == R_HL) begin
					b[0] = 8'h22; b[1] = lo; b[2] = hi; len = 3'd3;
				end else if (p != 8'h00) begin
					b[0] = p; b[1] = 8'h22; b[2] = lo; b[3] = hi; len = 3'd4;
				end else if (d.reg_right >= R_BC && d.reg_right <= R_SP) begin
					b[0] = 8'hED; b[1] = {2'b01, ps, 4'h3}; b[2] = lo; b[3] = hi;
					len = 3'd4;
				end
			end
			M_LD_SP: begin
				p = idx_prefix(d.reg_right);
				if (d.reg_left == R_SP && d.reg_right == R_HL) begin
					b[0] = 8'hF9; len = 3'd1;
				end else if (d.reg_left == R_SP && p != 8'h00) begin
					b[0] = p; b[1] = 8'hF9; len = 3'd2;
				end
			end
			M_PUSH, M_POP: begin
				p = idx_prefix(d.reg_left);
				ps = (d.reg_left == R_AF) ? 2'd3 : 2'(d.reg_left - R_BC);
				if (p != 8'h00) begin
					b[0] = p; b[1] = (d.mode == M_PUSH) ? 8'hE5 : 8'hE1; len = 3'd2;
				end else if ((d.reg_left >= R_BC && d.reg_left <= R_HL)
						|| d.reg_left == R_AF) begin
					b[0] = {2'b11, ps, (d.mode == M_PUSH) ? 4'h5 : 4'h1}; len = 3'd1;
				end
			end
			M_EX: begin
				if (d.reg_left == R_DE && d.reg_right == R_HL) begin
					b[0] = 8'hEB; len = 3'd1;
				end else if (d.reg_left == R_AF && d.reg_right == R_AF2) begin
					b[0] = 8'h08; len = 3'd1;
				end
			end
			M_EX_SP: begin
				p = idx_prefix(d.reg_right);
				if (d.reg_left == R_SP && d.reg_right == R_HL) begin
					b[0] = 8'hE3; len = 3'd1;
				end else if (d.reg_left == R_SP && p != 8'h00) begin
					b[0] = p; b[1] = 8'hE3; len = 3'd2;
				end
			end
			M_EXX: begin
				b[0] = 8'hD9; len = 3'd1;
			end
			default: begin
				if (d.mode >= M_BLK_LO && d.mode <= M_BLK_HI) begin
					// Block ops: bit 0 repeat, bit 1 decrement, bit 2 compare.
					b[0] = 8'hED;
					b[1] = {3'b101, blk[0], blk[1], 2'b00, blk[2]};
					len = 3'd2;
				end
			end
		endcase
	end

	assign end_pc = {1'b0, pc_q} + {15'd0, len};

	assign is_instr = d.mode <= M_BLK_HI;

	always_comb begin
		push_data.bytes = b;
		push_data.len = len;
		push_data.addr = pc_q[15:0];
		push_data.err = E_OK;
		if (len == 3'd0) begin
			push_data.err = E_REG;
			push_data.len = 3'd1;
			push_data.bytes = '0;
		end else if (end_pc > 18'(MEMORY_SIZE)) begin
			push_data.err = E_MEM;
			push_data.len = 3'd1;
			push_data.bytes = '0;
		end
	end

	assign push = in_ch.valid && in_ch.ready && is_instr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (in_ch.valid && in_ch.ready) begin
			if (d.mode == M_ORG)
				pc_q <= {1'b0, d.imm_word};
			else if (is_instr && push_data.err == E_OK)
				pc_q <= end_pc[16:0];
		end
	end

endmodule

>>> rtl/zlx_back.sv
// ----------------------------------------------------------------------------
// zlx_back: instruction queue and byte emitter
// Holds decoded instructions and sends their bytes out one per transaction.
// ----------------------------------------------------------------------------
module zlx_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  zlx_pkg::zlx_instr_t   push_data,
	output logic                  full,
	zlx_if.source                 out_ch
);
	import zlx_pkg::*;

	zlx_instr_t mem_q [QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	logic       pop;
	zlx_instr_t head;
	logic       last;
	zlx_out_t   o;

	assign head = mem_q[rp_q];
	assign full = cnt_q == 2'(QDEPTH);
	assign last = {1'b0, idx_q} == head.len - 3'd1;
	assign pop = out_ch.valid && out_ch.ready && last;

	always_comb begin
		o.out_byte = head.bytes[idx_q];
		o.out_address = head.addr + 16'(idx_q);
		o.last_byte = last;
		o.error_code = head.err;
	end
	assign out_ch.data = o;
	assign out_ch.valid = cnt_q != 2'd0;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (out_ch.valid && out_ch.ready) begin
				if (last) begin
					idx_q <= '0;
					rp_q <= ~rp_q;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> ({1'b0, idx_q} < head.len)) else $error("byte index past length");
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && head.err != E_OK) |-> last) else $error("error result not last");
	a_idx_reset: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 2'd0) else $error("index not cleared");
`endif

endmodule
